// ===== hw/rtl/mstk_pkg.sv =====
package mstk_pkg;

    localparam int unsigned VIDX_W  = 4;
    localparam int unsigned VCNT_W  = 5;

    typedef struct packed {
        logic insert;
        logic shift;
    } cell_cmd_t;

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_RUN   = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

endpackage

// ===== hw/rtl/max_spanning_tree_kruskal_core.sv =====
// Maximum spanning tree core.
// The s_ channel takes adjacency matrix entries, one transfer per cycle while
// the core is loading; tlast marks the final entry of a matrix. Each entry with
// a nonzero weight above the diagonal and inside vertex_count is inserted into a
// chain of cells that keeps edges sorted by descending signed weight, ties in
// arrival order. After the final entry, s_tready drops and the chain shifts one
// edge per cycle to its head, where the component labels are checked and merged.
// Each selected edge leaves on the m_ channel with tlast on the final one; an
// empty tree gives one transfer with tuser set. A pending register holds each
// selected edge until the next one or the end of the run, so tlast can be set;
// when the receiver stalls, the shifting chain waits with it.
// Reset empties the chain, sets vertex_count to 16 and returns to loading.
module max_spanning_tree_kruskal_core #(
    parameter int unsigned MAX_VERTICES = 16,
    parameter int unsigned WEIGHT_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [mstk_pkg::VCNT_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // row_index, col_index, edge_weight
    input  logic [((WEIGHT_BITS+15)/8)*8-1:0] s_tdata,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // tree_weight, tree_from, tree_to
    output logic [((WEIGHT_BITS+15)/8)*8-1:0] m_tdata,
    // tree_empty
    output logic                  m_tuser,
    output logic                  m_tlast
);

    localparam int unsigned DEPTH  = MAX_VERTICES * (MAX_VERTICES - 1) / 2;
    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
    localparam int unsigned VB     = $clog2(MAX_VERTICES);
    localparam int unsigned EW     = WEIGHT_BITS + 8;
    localparam int unsigned DW     = ((WEIGHT_BITS + 15) / 8) * 8;

    mstk_pkg::state_t state_reg, state_next;
    logic [mstk_pkg::VCNT_W-1:0] vcount_reg;
    logic [CNT_W-1:0] count_reg;
    logic [5:0]       live;
    logic [VB-1:0]    label_reg [MAX_VERTICES];
    logic             pend_valid_reg;
    logic [EW-1:0]    pend_reg;
    logic             m_valid_reg;
    logic [EW-1:0]    m_edge_reg;
    logic             m_empty_reg, m_last_reg;

    logic [EW-1:0]    chain_edge  [DEPTH];
    logic             chain_valid [DEPTH];
    logic             chain_stays [DEPTH];
    mstk_pkg::cell_cmd_t cmd;

    logic [mstk_pkg::VIDX_W-1:0] in_row, in_col;
    logic [WEIGHT_BITS-1:0] in_w;
    logic        in_accept, store;
    logic        out_free;
    logic [EW-1:0] head;
    logic [mstk_pkg::VIDX_W-1:0] hf, ht;
    logic [VB-1:0] c1, c2;
    logic        in_range, select;

    assign live = ({1'b0, vcount_reg} > 6'(MAX_VERTICES)) ? 6'(MAX_VERTICES)
                                                          : {1'b0, vcount_reg};

    assign in_row = s_tdata[3:0];
    assign in_col = s_tdata[7:4];
    assign in_w   = s_tdata[WEIGHT_BITS+7:8];
    assign s_tready  = (state_reg == mstk_pkg::ST_LOAD);
    assign in_accept = s_tvalid && s_tready;
    assign store = in_accept && (in_w != '0) && (in_row < in_col)
                   && ({2'b00, in_col} < live) && (count_reg < CNT_W'(DEPTH));

    assign out_free = !m_valid_reg || m_tready;
    assign cmd.insert = store;
    assign cmd.shift  = (state_reg == mstk_pkg::ST_RUN) && out_free;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [EW-1:0] pe, ne;
        logic pv, ps, nv;
        if (i == 0) begin : g_first
            assign pe = '0;
            assign pv = 1'b0;
            assign ps = 1'b1;
        end else begin : g_mid
            assign pe = chain_edge[i-1];
            assign pv = chain_valid[i-1];
            assign ps = chain_stays[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign ne = '0;
            assign nv = 1'b0;
        end else begin : g_inner
            assign ne = chain_edge[i+1];
            assign nv = chain_valid[i+1];
        end
        mstk_cell #(.WEIGHT_BITS(WEIGHT_BITS)) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .new_edge   ({in_w, in_col, in_row}),
            .prev_edge  (pe),
            .prev_valid (pv),
            .prev_stays (ps),
            .next_edge  (ne),
            .next_valid (nv),
            .edge_q     (chain_edge[i]),
            .valid_q    (chain_valid[i]),
            .stays      (chain_stays[i])
        );
    end

    assign head = chain_edge[0];
    assign hf = head[3:0];
    assign ht = head[7:4];
    assign in_range = ({2'b00, hf} < live) && ({2'b00, ht} < live);
    assign c1 = label_reg[VB'(hf)];
    assign c2 = label_reg[VB'(ht)];
    assign select = chain_valid[0] && in_range && (c1 != c2);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mstk_pkg::ST_LOAD: begin
                if (in_accept && s_tlast) state_next = mstk_pkg::ST_RUN;
            end
            mstk_pkg::ST_RUN: begin
                if (!chain_valid[0]) state_next = mstk_pkg::ST_FLUSH;
            end
            mstk_pkg::ST_FLUSH: begin
                if (out_free) state_next = mstk_pkg::ST_LOAD;
            end
            default: state_next = mstk_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= mstk_pkg::ST_LOAD;
            vcount_reg     <= 5'd16;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) vcount_reg <= cfg_wr_data;
            if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;
            if (store) count_reg <= count_reg + 1'b1;
            if (state_reg == mstk_pkg::ST_RUN && out_free && chain_valid[0] && select) begin
                pend_valid_reg <= 1'b1;
                pend_reg       <= head;
                if (pend_valid_reg) begin
                    m_valid_reg <= 1'b1;
                    m_edge_reg  <= pend_reg;
                    m_empty_reg <= 1'b0;
                    m_last_reg  <= 1'b0;
                end
            end
            if (state_reg == mstk_pkg::ST_FLUSH && out_free) begin
                m_valid_reg    <= 1'b1;
                m_edge_reg     <= pend_valid_reg ? pend_reg : '0;
                m_empty_reg    <= !pend_valid_reg;
                m_last_reg     <= 1'b1;
                pend_valid_reg <= 1'b0;
                count_reg      <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < MAX_VERTICES; j++) begin
            if (in_accept && s_tlast) begin
                label_reg[j] <= VB'(j);
            end else if (state_reg == mstk_pkg::ST_RUN && out_free && select
                         && label_reg[j] == c2) begin
                label_reg[j] <= c1;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DW'({m_edge_reg[7:4], m_edge_reg[3:0], m_edge_reg[EW-1:8]});
    assign m_tuser  = m_empty_reg;
    assign m_tlast  = m_last_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("edge count beyond store depth");
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_empty_reg |-> m_last_reg)
        else $error("empty result without last flag");
    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == mstk_pkg::ST_RUN && !chain_valid[0] |=> state_reg == mstk_pkg::ST_FLUSH)
        else $error("run did not end after the chain drained");
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == mstk_pkg::ST_LOAD |-> !pend_valid_reg)
        else $error("pending result while loading");

endmodule

// ===== hw/rtl/mstk_cell.sv =====
module mstk_cell #(
    parameter int unsigned WEIGHT_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mstk_pkg::cell_cmd_t           cmd,
    input  logic [WEIGHT_BITS+7:0]        new_edge,
    input  logic [WEIGHT_BITS+7:0]        prev_edge,
    input  logic                          prev_valid,
    input  logic                          prev_stays,
    input  logic [WEIGHT_BITS+7:0]        next_edge,
    input  logic                          next_valid,
    output logic [WEIGHT_BITS+7:0]        edge_q,
    output logic                          valid_q,
    output logic                          stays
);

    logic [WEIGHT_BITS+7:0] edge_reg, edge_next;
    logic                   valid_reg, valid_next;
    logic signed [WEIGHT_BITS-1:0] own_w, new_w;

    assign own_w = $signed(edge_reg[WEIGHT_BITS+7:8]);
    assign new_w = $signed(new_edge[WEIGHT_BITS+7:8]);
    assign stays = valid_reg && !(own_w < new_w);

    always_comb begin
        edge_next  = edge_reg;
        valid_next = valid_reg;
        if (cmd.insert && !stays) begin
            if (prev_stays) begin
                edge_next  = new_edge;
                valid_next = 1'b1;
            end else begin
                edge_next  = prev_edge;
                valid_next = prev_valid;
            end
        end else if (cmd.shift) begin
            edge_next  = next_edge;
            valid_next = next_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        edge_reg <= edge_next;
    end

    assign edge_q  = edge_reg;
    assign valid_q = valid_reg;

endmodule
